>>> design/dtt_pkg.sv
// ----------------------------------------------------------------------------
// dtt_pkg: shared definitions for the delimited text tokenizer
// widths, unit codes, event kinds, register indexes and the state/event types
// ----------------------------------------------------------------------------
package dtt_pkg;

    localparam int UNIT_W = 16;
    localparam int COL_W  = 9;
    localparam int ROW_W  = 21;
    localparam int NUM_SLOTS = 4;

    // unit codes
    localparam logic [UNIT_W-1:0] QUOTE_UNIT = 16'd34;
    localparam logic [UNIT_W-1:0] LF_UNIT    = 16'd10;
    localparam logic [UNIT_W-1:0] CR_UNIT    = 16'd13;

    // limits and register reset values
    localparam logic [COL_W-1:0]  COLUMN_MAX      = 9'd256;
    localparam logic [ROW_W-1:0]  ROW_MAX         = 21'd1048576;
    localparam logic [UNIT_W-1:0] DELIMITER_RESET = 16'd44;

    // event kinds
    localparam logic [1:0] EV_CHAR      = 2'd0;
    localparam logic [1:0] EV_FIELD_END = 2'd1;
    localparam logic [1:0] EV_ROW_END   = 2'd2;
    localparam logic [1:0] EV_TABLE_END = 2'd3;

    // quote modes
    localparam logic [1:0] QM_OUT  = 2'd0;
    localparam logic [1:0] QM_IN   = 2'd1;
    localparam logic [1:0] QM_PEND = 2'd2;

    // register indexes
    localparam logic [1:0] REG_DELIMITER = 2'd0;
    localparam logic [1:0] REG_ROW_LIMIT = 2'd1;
    localparam logic [1:0] REG_COL_LIMIT = 2'd2;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              no_unit;
        logic              end_of_text;
    } item_t;

    typedef struct packed {
        logic [UNIT_W-1:0] delimiter_unit;
        logic [ROW_W-1:0]  row_limit;
        logic [COL_W-1:0]  column_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       quote_mode;
        logic             skip_line_feed;
        logic             field_is_empty;
        logic             row_has_content;
        logic [COL_W-1:0] kept_columns;
        logic [ROW_W-1:0] kept_rows;
        logic             rows_cut_flag;
        logic             columns_cut_flag;
        logic             stopped;
    } state_t;

    localparam state_t STATE_RESET = '{
        quote_mode:       QM_OUT,
        skip_line_feed:   1'b0,
        field_is_empty:   1'b1,
        row_has_content:  1'b0,
        kept_columns:     '0,
        kept_rows:        '0,
        rows_cut_flag:    1'b0,
        columns_cut_flag: 1'b0,
        stopped:          1'b0
    };

    typedef struct packed {
        logic [1:0]        event_kind;
        logic [UNIT_W-1:0] field_unit;
        logic [7:0]        column_index;
        logic [19:0]       row_index;
        logic              rows_cut;
        logic              columns_cut;
    } event_t;

    typedef struct packed {
        logic [2:0]                 count;
        event_t [NUM_SLOTS-1:0]     ev;
    } bundle_t;

endpackage

>>> design/dtt_in_if.sv
// ----------------------------------------------------------------------------
// dtt_in_if: text input channel
// one code unit request per handshake
// ----------------------------------------------------------------------------
interface dtt_in_if;
    logic                       valid;
    logic                       ready;
    logic [dtt_pkg::UNIT_W-1:0] code_unit;
    logic                       no_unit;
    logic                       end_of_text;

    modport source (output valid, output code_unit, output no_unit, output end_of_text,
                    input ready);
    modport sink   (input valid, input code_unit, input no_unit, input end_of_text,
                    output ready);
endinterface

>>> design/dtt_out_if.sv
// ----------------------------------------------------------------------------
// dtt_out_if: token event output channel
// one event per handshake
// ----------------------------------------------------------------------------
interface dtt_out_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 event_kind;
    logic [dtt_pkg::UNIT_W-1:0] field_unit;
    logic [7:0]                 column_index;
    logic [19:0]                row_index;
    logic                       rows_cut;
    logic                       columns_cut;
    logic                       last_event;

    modport source (output valid, output event_kind, output field_unit,
                    output column_index, output row_index, output rows_cut,
                    output columns_cut, output last_event, input ready);
    modport sink   (input valid, input event_kind, input field_unit,
                    input column_index, input row_index, input rows_cut,
                    input columns_cut, input last_event, output ready);
endinterface

>>> design/dtt_cfg_if.sv
// ----------------------------------------------------------------------------
// dtt_cfg_if: configuration write channel
// register index and write data per handshake
// ----------------------------------------------------------------------------
interface dtt_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [31:0] write_data;

    modport source (output valid, output reg_index, output write_data, input ready);
    modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

>>> design/dtt_step.sv
// ----------------------------------------------------------------------------
// dtt_step: per-unit tokenizer decision
// next state and up to four events for one registered request
// ----------------------------------------------------------------------------
module dtt_step (
    input  dtt_pkg::state_t  st,
    input  dtt_pkg::item_t   item,
    input  dtt_pkg::cfg_t    cfg,
    output dtt_pkg::state_t  st_next,
    output dtt_pkg::bundle_t bundle
);

    typedef struct packed {
        dtt_pkg::state_t s;
        logic            emit;
    } close_res_t;

    logic [dtt_pkg::COL_W-1:0] eff_cols;
    logic [dtt_pkg::ROW_W-1:0] eff_rows;

    assign eff_cols = (cfg.column_limit < dtt_pkg::COLUMN_MAX) ? cfg.column_limit
                                                                 : dtt_pkg::COLUMN_MAX;
    assign eff_rows = (cfg.row_limit < dtt_pkg::ROW_MAX) ? cfg.row_limit : dtt_pkg::ROW_MAX;

    function automatic dtt_pkg::event_t mk_ev(
        input logic [1:0]                kind,
        input logic [dtt_pkg::UNIT_W-1:0] unit,
        input logic [dtt_pkg::COL_W-1:0]  col,
        input logic [dtt_pkg::ROW_W-1:0]  row,
        input dtt_pkg::state_t            s
    );
        dtt_pkg::event_t e;
        e.event_kind   = kind;
        e.field_unit   = unit;
        e.column_index = col[7:0];
        e.row_index    = row[19:0];
        e.rows_cut     = s.rows_cut_flag;
        e.columns_cut  = s.columns_cut_flag;
        return e;
    endfunction

    // field close: count the column or flag the drop
    function automatic close_res_t close_field(
        input dtt_pkg::state_t           s,
        input logic [dtt_pkg::COL_W-1:0] ecols,
        input logic [dtt_pkg::ROW_W-1:0] erows
    );
        close_res_t r;
        r.s    = s;
        r.emit = 1'b0;
        if (s.kept_columns < ecols)
        begin
            r.emit           = (s.kept_rows < erows);
            r.s.kept_columns = s.kept_columns + 1'b1;
        end
        else
        begin
            r.s.columns_cut_flag = 1'b1;
        end
        if (!s.field_is_empty)
        begin
            r.s.row_has_content = 1'b1;
        end
        r.s.field_is_empty = 1'b1;
        return r;
    endfunction

    always_comb
    begin
        dtt_pkg::state_t           s;
        dtt_pkg::event_t [3:0]     ev;
        close_res_t                fr;
        logic [2:0]                cnt;
        logic [dtt_pkg::UNIT_W-1:0] u;
        logic [dtt_pkg::UNIT_W-1:0] app_unit;
        logic                      do_app;
        logic                      do_delim;
        logic                      do_row;
        logic                      row_go;
        logic                      skip;
        logic                      outside;

        s        = st;
        ev       = '0;
        fr       = '0;
        cnt      = 3'd0;
        u        = item.code_unit;
        app_unit = item.code_unit;
        do_app   = 1'b0;
        do_delim = 1'b0;
        do_row   = 1'b0;
        row_go   = 1'b0;
        skip     = 1'b0;
        outside  = 1'b0;

        // classify the unit
        if (!s.stopped && !item.no_unit)
        begin
            skip             = s.skip_line_feed && (u == dtt_pkg::LF_UNIT);
            s.skip_line_feed = 1'b0;
            if (!skip)
            begin
                case (s.quote_mode)
                    dtt_pkg::QM_IN:
                    begin
                        if (u == dtt_pkg::QUOTE_UNIT)
                            s.quote_mode = dtt_pkg::QM_PEND;
                        else
                            do_app = 1'b1;
                    end
                    dtt_pkg::QM_PEND:
                    begin
                        if (u == dtt_pkg::QUOTE_UNIT)
                        begin
                            do_app       = 1'b1;
                            app_unit     = dtt_pkg::QUOTE_UNIT;
                            s.quote_mode = dtt_pkg::QM_IN;
                        end
                        else
                        begin
                            s.quote_mode = dtt_pkg::QM_OUT;
                            outside      = 1'b1;
                        end
                    end
                    default:
                    begin
                        outside = 1'b1;
                    end
                endcase

                if (outside)
                begin
                    if (u == dtt_pkg::QUOTE_UNIT && s.field_is_empty)
                    begin
                        s.quote_mode      = dtt_pkg::QM_IN;
                        s.row_has_content = 1'b1;
                    end
                    else if (u == cfg.delimiter_unit)
                    begin
                        do_delim = 1'b1;
                    end
                    else if (u == dtt_pkg::LF_UNIT || u == dtt_pkg::CR_UNIT)
                    begin
                        do_row = 1'b1;
                        if (u == dtt_pkg::CR_UNIT)
                            s.skip_line_feed = 1'b1;
                    end
                    else
                    begin
                        do_app = 1'b1;
                    end
                end
            end
        end

        // append a character
        if (do_app)
        begin
            if (s.kept_columns < eff_cols && s.kept_rows < eff_rows)
            begin
                ev[cnt[1:0]] = mk_ev(dtt_pkg::EV_CHAR, app_unit, s.kept_columns,
                                     s.kept_rows, s);
                cnt = cnt + 3'd1;
            end
            s.field_is_empty = 1'b0;
        end

        // delimiter ends the field
        if (do_delim)
        begin
            fr = close_field(s, eff_cols, eff_rows);
            if (fr.emit && cnt < 3'd4)
            begin
                ev[cnt[1:0]] = mk_ev(dtt_pkg::EV_FIELD_END, '0, s.kept_columns,
                                     s.kept_rows, s);
                cnt = cnt + 3'd1;
            end
            s                 = fr.s;
            s.row_has_content = 1'b1;
        end

        // row end from a line break, then row end from end of text
        for (int p = 0; p < 2; p++)
        begin
            if (p == 0)
                row_go = do_row;
            else
                row_go = item.end_of_text && !s.stopped &&
                         (s.row_has_content || !s.field_is_empty);
            if (row_go)
            begin
                if (!s.row_has_content && s.field_is_empty)
                begin
                    if (s.kept_columns >= eff_cols)
                        s.columns_cut_flag = 1'b1;
                end
                else
                begin
                    fr = close_field(s, eff_cols, eff_rows);
                    if (fr.emit && cnt < 3'd4)
                    begin
                        ev[cnt[1:0]] = mk_ev(dtt_pkg::EV_FIELD_END, '0, s.kept_columns,
                                             s.kept_rows, s);
                        cnt = cnt + 3'd1;
                    end
                    s = fr.s;
                    if (s.kept_rows < eff_rows)
                    begin
                        if (cnt < 3'd4)
                        begin
                            ev[cnt[1:0]] = mk_ev(dtt_pkg::EV_ROW_END, '0, '0, s.kept_rows, s);
                            cnt = cnt + 3'd1;
                        end
                        s.kept_rows = s.kept_rows + 1'b1;
                    end
                    else
                    begin
                        s.rows_cut_flag = 1'b1;
                        s.stopped       = 1'b1;
                    end
                end
                s.kept_columns    = '0;
                s.row_has_content = 1'b0;
                s.field_is_empty  = 1'b1;
            end
        end

        // table end and return to the reset state
        if (item.end_of_text)
        begin
            if (cnt < 3'd4)
            begin
                ev[cnt[1:0]] = mk_ev(dtt_pkg::EV_TABLE_END, '0, '0, '0, s);
                cnt = cnt + 3'd1;
            end
            s = dtt_pkg::STATE_RESET;
        end

        st_next      = s;
        bundle.count = cnt;
        bundle.ev    = ev;
    end

endmodule

>>> design/dtt_emit.sv
// ----------------------------------------------------------------------------
// dtt_emit: event result register
// holds a request's events and, with token ready, hands them out one per cycle
// ----------------------------------------------------------------------------
module dtt_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  dtt_pkg::bundle_t  bundle_in,
    output logic              free,
    dtt_out_if.source         token
);

    logic             valid_reg;
    logic             valid_next;
    logic [1:0]       idx_reg;
    logic [1:0]       idx_next;
    dtt_pkg::bundle_t bun_reg;
    dtt_pkg::event_t  cur;
    logic             is_last;
    logic             take;

    assign cur     = bun_reg.ev[idx_reg];
    assign is_last = ({1'b0, idx_reg} == (bun_reg.count - 3'd1));
    assign take    = valid_reg && token.ready;
    assign free    = !valid_reg || (take && is_last);

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
        else if (take)
        begin
            if (is_last)
                valid_next = 1'b0;
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            bun_reg <= bundle_in;
    end

    assign token.valid        = valid_reg;
    assign token.event_kind   = cur.event_kind;
    assign token.field_unit   = cur.field_unit;
    assign token.column_index = cur.column_index;
    assign token.row_index    = cur.row_index;
    assign token.rows_cut     = cur.rows_cut;
    assign token.columns_cut  = cur.columns_cut;
    assign token.last_event   = is_last;

endmodule

>>> design/delimited_text_tokenizer_core.sv
// ----------------------------------------------------------------------------
// delimited_text_tokenizer_core: delimited text tokenizer
// turns a stream of UTF-16 code units into character, field, row and table
// events, with quoting, CR/LF handling and row/column limits
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake          | carries
//  ---------+-----+--------------------+-----------------------------------------
//  text     | in  | valid/ready        | code_unit, no_unit, end_of_text
//  token    | out | valid/ready        | one event per handshake, last_event marks
//           |     |                    | the final event of a code unit
//  cfg      | in  | valid/ready        | reg_index, write_data (always ready)
//
//  a code unit is held in the input register, decided combinationally and
//  its events loaded into the event register, which offers the first event;
//  the core takes one code unit per cycle while each unit makes at most one
//  event and the token side is ready; a unit with n events holds the event
//  register until all n are taken (n is at most four); units that make no
//  event pass through without touching the event register
//  reset clears tokenizer state and loads delimiter 44 and both limits at max
//  a stalled token channel fills the event register, then the input register,
//  then drops text.ready
module delimited_text_tokenizer_core (
    input  logic       clk,
    input  logic       rst_n,
    dtt_in_if.sink     text,
    dtt_out_if.source  token,
    dtt_cfg_if.sink    cfg
);

    // configuration registers
    dtt_pkg::cfg_t     cfg_reg;
    dtt_pkg::cfg_t     cfg_next;

    // input register
    logic              in_valid_reg;
    logic              in_valid_next;
    dtt_pkg::item_t    item_reg;

    // tokenizer state
    dtt_pkg::state_t   state_reg;
    dtt_pkg::state_t   state_next;

    dtt_pkg::bundle_t  bundle;
    logic              emit_free;
    logic              advance;
    logic              text_take;

    // config channel never stalls; the user must write only while idle, the block does not enforce it
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.reg_index)
                dtt_pkg::REG_DELIMITER:
                    cfg_next.delimiter_unit = cfg.write_data[dtt_pkg::UNIT_W-1:0];
                dtt_pkg::REG_ROW_LIMIT:
                    cfg_next.row_limit = cfg.write_data[dtt_pkg::ROW_W-1:0];
                dtt_pkg::REG_COL_LIMIT:
                    cfg_next.column_limit = cfg.write_data[dtt_pkg::COL_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // the decided unit leaves the input register once the event register
    // is empty or hands out its last event this cycle
    assign advance   = in_valid_reg && emit_free;
    assign text.ready = !in_valid_reg || emit_free;
    assign text_take = text.valid && text.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (text_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delimiter_unit <= dtt_pkg::DELIMITER_RESET;
            cfg_reg.row_limit      <= dtt_pkg::ROW_MAX;
            cfg_reg.column_limit   <= dtt_pkg::COLUMN_MAX;
            in_valid_reg           <= 1'b0;
            state_reg              <= dtt_pkg::STATE_RESET;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            in_valid_reg <= in_valid_next;
            // state moves with the unit that is being decided
            if (advance)
                state_reg <= state_next;
        end
    end

    // payload of the input register
    always_ff @(posedge clk)
    begin
        if (text_take)
        begin
            item_reg.code_unit   <= text.code_unit;
            item_reg.no_unit     <= text.no_unit;
            item_reg.end_of_text <= text.end_of_text;
        end
    end

    // per-unit decision: quoting, delimiters, line breaks and limits
    dtt_step u_step (
        .st      (state_reg),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .st_next (state_next),
        .bundle  (bundle)
    );

    // event register, only loaded when the unit produced events
    dtt_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && (bundle.count != 3'd0)),
        .bundle_in (bundle),
        .free      (emit_free),
        .token     (token)
    );

    // a table end is always the final event of its unit
    a_table_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (token.valid && token.event_kind == dtt_pkg::EV_TABLE_END) |-> token.last_event)
        else $error("table end not marked as last event");

    // end of text returns the tokenizer to its reset state
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.end_of_text) |=> (state_reg == dtt_pkg::STATE_RESET))
        else $error("state not cleared after end of text");

    // text only stalls while the event register holds undelivered events
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !text.ready |-> (token.valid && !(token.ready && token.last_event)))
        else $error("text stalled without pending events");

endmodule

>>> tb/sv/token_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// token_stream_checker: event predictor and scoreboard for the tokenizer
// watches the text, token and cfg channels, keeps its own copy of the
// tokenizer state and registers, and compares every token event in order
// ----------------------------------------------------------------------------
module token_stream_checker (
    input  logic clk,
    input  logic rst_n,
    dtt_in_if    text,
    dtt_out_if   token,
    dtt_cfg_if   cfg,
    output int   mismatches,
    output int   outstanding,
    output int   events_checked
);

    typedef struct packed {
        dtt_pkg::event_t ev;
        logic            last;
    } token_exp_t;

    logic [dtt_pkg::UNIT_W-1:0] delim_reg;
    logic [dtt_pkg::ROW_W-1:0]  row_limit_reg;
    logic [dtt_pkg::COL_W-1:0]  col_limit_reg;
    dtt_pkg::state_t            tok;

    token_exp_t expected_events[$];
    token_exp_t request_events[$];

    function automatic logic [dtt_pkg::COL_W-1:0] column_cap();
        return (col_limit_reg < dtt_pkg::COLUMN_MAX) ? col_limit_reg : dtt_pkg::COLUMN_MAX;
    endfunction

    function automatic logic [dtt_pkg::ROW_W-1:0] row_cap();
        return (row_limit_reg < dtt_pkg::ROW_MAX) ? row_limit_reg : dtt_pkg::ROW_MAX;
    endfunction

    // at most four events per request, flags taken at emit time
    function automatic void emit_event(logic [1:0] kind, logic [dtt_pkg::UNIT_W-1:0] unit,
                                       logic [dtt_pkg::COL_W-1:0] col,
                                       logic [dtt_pkg::ROW_W-1:0] row);
        token_exp_t t;
        if (request_events.size() >= dtt_pkg::NUM_SLOTS)
            return;
        t.ev.event_kind   = kind;
        t.ev.field_unit   = unit;
        t.ev.column_index = col[7:0];
        t.ev.row_index    = row[19:0];
        t.ev.rows_cut     = tok.rows_cut_flag;
        t.ev.columns_cut  = tok.columns_cut_flag;
        t.last            = 1'b0;
        request_events.push_back(t);
    endfunction

    function automatic void append_char(logic [dtt_pkg::UNIT_W-1:0] unit);
        if (tok.kept_columns < column_cap() && tok.kept_rows < row_cap())
            emit_event(dtt_pkg::EV_CHAR, unit, tok.kept_columns, tok.kept_rows);
        tok.field_is_empty = 1'b0;
    endfunction

    function automatic void close_field();
        if (tok.kept_columns < column_cap())
        begin
            if (tok.kept_rows < row_cap())
                emit_event(dtt_pkg::EV_FIELD_END, '0, tok.kept_columns, tok.kept_rows);
            tok.kept_columns = tok.kept_columns + 1'b1;
        end
        else
            tok.columns_cut_flag = 1'b1;
        if (!tok.field_is_empty)
            tok.row_has_content = 1'b1;
        tok.field_is_empty = 1'b1;
    endfunction

    function automatic void close_row();
        if (!tok.row_has_content && tok.field_is_empty)
        begin
            // blank line: no events, only the column flag can move
            if (tok.kept_columns >= column_cap())
                tok.columns_cut_flag = 1'b1;
        end
        else
        begin
            close_field();
            if (tok.kept_rows < row_cap())
            begin
                emit_event(dtt_pkg::EV_ROW_END, '0, '0, tok.kept_rows);
                tok.kept_rows = tok.kept_rows + 1'b1;
            end
            else
            begin
                tok.rows_cut_flag = 1'b1;
                tok.stopped       = 1'b1;
            end
        end
        tok.kept_columns    = '0;
        tok.row_has_content = 1'b0;
        tok.field_is_empty  = 1'b1;
    endfunction

    function automatic void unquoted_unit(logic [dtt_pkg::UNIT_W-1:0] unit);
        if (unit == dtt_pkg::QUOTE_UNIT && tok.field_is_empty)
        begin
            tok.quote_mode      = dtt_pkg::QM_IN;
            tok.row_has_content = 1'b1;
        end
        else if (unit == delim_reg)
        begin
            close_field();
            tok.row_has_content = 1'b1;
        end
        else if (unit == dtt_pkg::LF_UNIT || unit == dtt_pkg::CR_UNIT)
        begin
            close_row();
            if (unit == dtt_pkg::CR_UNIT)
                tok.skip_line_feed = 1'b1;
        end
        else
            append_char(unit);
    endfunction

    function automatic void tokenize_request(dtt_pkg::item_t req);
        token_exp_t t;
        logic       skip;
        request_events.delete();
        if (!tok.stopped && !req.no_unit)
        begin
            skip = tok.skip_line_feed && req.code_unit == dtt_pkg::LF_UNIT;
            tok.skip_line_feed = 1'b0;
            if (!skip)
            begin
                case (tok.quote_mode)
                    dtt_pkg::QM_IN:
                    begin
                        if (req.code_unit == dtt_pkg::QUOTE_UNIT)
                            tok.quote_mode = dtt_pkg::QM_PEND;
                        else
                            append_char(req.code_unit);
                    end
                    dtt_pkg::QM_PEND:
                    begin
                        if (req.code_unit == dtt_pkg::QUOTE_UNIT)
                        begin
                            append_char(dtt_pkg::QUOTE_UNIT);
                            tok.quote_mode = dtt_pkg::QM_IN;
                        end
                        else
                        begin
                            tok.quote_mode = dtt_pkg::QM_OUT;
                            unquoted_unit(req.code_unit);
                        end
                    end
                    default: unquoted_unit(req.code_unit);
                endcase
            end
        end
        if (req.end_of_text)
        begin
            if (!tok.stopped && (tok.row_has_content || !tok.field_is_empty))
                close_row();
            emit_event(dtt_pkg::EV_TABLE_END, '0, '0, '0);
            tok = dtt_pkg::STATE_RESET;
        end
        if (request_events.size() > 0)
        begin
            t = request_events.pop_back();
            t.last = 1'b1;
            request_events.push_back(t);
        end
        while (request_events.size() > 0)
            expected_events.push_back(request_events.pop_front());
    endfunction

    function automatic bit field_differs(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        token_exp_t     want;
        dtt_pkg::item_t req;
        bit             bad;
        if (!rst_n)
        begin
            delim_reg      = dtt_pkg::DELIMITER_RESET;
            row_limit_reg  = dtt_pkg::ROW_MAX;
            col_limit_reg  = dtt_pkg::COLUMN_MAX;
            tok            = dtt_pkg::STATE_RESET;
            mismatches     = 0;
            events_checked = 0;
            expected_events.delete();
        end
        else
        begin
            if (token.valid && token.ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("token event kind %0d with no prediction pending", token.event_kind);
                    mismatches++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    bad  = 1'b0;
                    bad |= field_differs("event_kind", 32'(want.ev.event_kind),
                                         32'(token.event_kind));
                    bad |= field_differs("field_unit", 32'(want.ev.field_unit),
                                         32'(token.field_unit));
                    bad |= field_differs("column_index", 32'(want.ev.column_index),
                                         32'(token.column_index));
                    bad |= field_differs("row_index", 32'(want.ev.row_index),
                                         32'(token.row_index));
                    bad |= field_differs("rows_cut", 32'(want.ev.rows_cut),
                                         32'(token.rows_cut));
                    bad |= field_differs("columns_cut", 32'(want.ev.columns_cut),
                                         32'(token.columns_cut));
                    bad |= field_differs("last_event", 32'(want.last),
                                         32'(token.last_event));
                    if (bad)
                        mismatches++;
                    events_checked++;
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.reg_index)
                    dtt_pkg::REG_DELIMITER: delim_reg     = cfg.write_data[dtt_pkg::UNIT_W-1:0];
                    dtt_pkg::REG_ROW_LIMIT: row_limit_reg = cfg.write_data[dtt_pkg::ROW_W-1:0];
                    dtt_pkg::REG_COL_LIMIT: col_limit_reg = cfg.write_data[dtt_pkg::COL_W-1:0];
                    default: ;
                endcase
            end
            if (text.valid && text.ready)
            begin
                req.code_unit   = text.code_unit;
                req.no_unit     = text.no_unit;
                req.end_of_text = text.end_of_text;
                tokenize_request(req);
            end
        end
        outstanding = expected_events.size();
    end

endmodule

>>> tb/sv/tb_delimited_text_tokenizer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_delimited_text_tokenizer_core: stimulus and verdict for the tokenizer
// a directed pass over quoting, line ends and text ends, then random tables
// and noise under many delimiter and limit settings, with random gaps on
// the text side and random stalls on the token side
// ----------------------------------------------------------------------------
module tb_delimited_text_tokenizer_core;

    localparam int  TARGET_ITEMS  = 200;         // no new phase past this, last one overshoots
    localparam int  PHASE_ITEMS   = 20;          // minimum text requests per register setting
    localparam int  DRAIN_CYCLES  = 8;           // pipeline is two deep, keep margin
    localparam int  MAX_GAP       = 17;
    localparam time WATCHDOG_NS   = 4_000_000;

    logic clk = 1'b0;
    logic rst_n;

    dtt_in_if  text_ch();
    dtt_out_if token_ch();
    dtt_cfg_if cfg_ch();

    int mismatches;
    int outstanding;
    int events_checked;

    // stimulus bookkeeping
    dtt_pkg::item_t             text_items[$];
    logic [dtt_pkg::UNIT_W-1:0] cur_delim = dtt_pkg::DELIMITER_RESET;
    int                         items_sent = 0;
    int                         phase_count = 0;
    bit                         sender_eager = 1'b0;
    bit                         token_eager = 1'b0;

    always #10 clk = ~clk;

    delimited_text_tokenizer_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_ch),
        .token (token_ch),
        .cfg   (cfg_ch)
    );

    token_stream_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .text           (text_ch),
        .token          (token_ch),
        .cfg            (cfg_ch),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .events_checked (events_checked)
    );

    // hard stop in case a request or an event never arrives
    initial
    begin
        #(WATCHDOG_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // token side: random stalls per event, with stretches of no stalls
    initial
    begin : token_drain
        int stall;
        token_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                token_eager = !token_eager;
            stall = token_eager ? 0 : int'($urandom_range(0, MAX_GAP));
            if (stall > 0)
            begin
                token_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            token_ch.ready <= 1'b1;
            do @(posedge clk); while (!token_ch.valid);
        end
    end

    task automatic queue_item(logic [dtt_pkg::UNIT_W-1:0] unit, logic none, logic last);
        dtt_pkg::item_t it;
        it.code_unit   = unit;
        it.no_unit     = none;
        it.end_of_text = last;
        text_items.push_back(it);
    endtask

    task automatic queue_unit(logic [dtt_pkg::UNIT_W-1:0] unit);
        queue_item(unit, 1'b0, 1'b0);
    endtask

    // a unit that is none of quote, cr, lf or the current delimiter
    function automatic logic [dtt_pkg::UNIT_W-1:0] plain_unit();
        logic [dtt_pkg::UNIT_W-1:0] u;
        do
        begin
            if ($urandom_range(0, 3) == 0)
                u = 16'($urandom);
            else
                u = 16'($urandom_range(97, 122));
        end
        while (u == dtt_pkg::QUOTE_UNIT || u == dtt_pkg::LF_UNIT || u == dtt_pkg::CR_UNIT ||
               u == cur_delim);
        return u;
    endfunction

    // close the text: either flag the last unit or append an empty end request
    task automatic finish_text();
        dtt_pkg::item_t it;
        if (text_items.size() == 0 || $urandom_range(0, 3) == 0)
            queue_item(16'($urandom), 1'b1, 1'b1);
        else
        begin
            it = text_items.pop_back();
            it.end_of_text = 1'b1;
            text_items.push_back(it);
        end
    endtask

    // well-formed table with random content, quoted fields and mixed line ends
    task automatic build_table();
        int rows;
        int fields;
        int len;
        int r;
        int f;
        rows = $urandom_range(1, 5);
        for (r = 0; r < rows; r++)
        begin
            if ($urandom_range(0, 7) == 0)
                queue_unit(dtt_pkg::LF_UNIT);       // blank line
            fields = $urandom_range(1, 5);
            for (f = 0; f < fields; f++)
            begin
                if (f > 0)
                    queue_unit(cur_delim);
                len = $urandom_range(0, 4);
                if ($urandom_range(0, 2) == 0)
                begin
                    queue_unit(dtt_pkg::QUOTE_UNIT);
                    repeat (len)
                    begin
                        case ($urandom_range(0, 7))
                            0:
                            begin
                                queue_unit(dtt_pkg::QUOTE_UNIT);
                                queue_unit(dtt_pkg::QUOTE_UNIT);
                            end
                            1: queue_unit(cur_delim);
                            2: queue_unit($urandom_range(0, 1) ? dtt_pkg::CR_UNIT
                                                               : dtt_pkg::LF_UNIT);
                            default: queue_unit(plain_unit());
                        endcase
                    end
                    queue_unit(dtt_pkg::QUOTE_UNIT);
                end
                else
                    repeat (len) queue_unit(plain_unit());
            end
            // last row is sometimes left unterminated
            if (r < rows - 1 || $urandom_range(0, 1) == 1)
            begin
                case ($urandom_range(0, 2))
                    0: queue_unit(dtt_pkg::LF_UNIT);
                    1: queue_unit(dtt_pkg::CR_UNIT);
                    default:
                    begin
                        queue_unit(dtt_pkg::CR_UNIT);
                        queue_unit(dtt_pkg::LF_UNIT);
                    end
                endcase
            end
        end
        finish_text();
    endtask

    // broken input: special units in any order, text end sometimes missing
    task automatic build_noise();
        int n;
        n = $urandom_range(3, 12);
        repeat (n)
        begin
            case ($urandom_range(0, 5))
                0: queue_unit(dtt_pkg::QUOTE_UNIT);
                1: queue_unit(cur_delim);
                2: queue_unit(dtt_pkg::CR_UNIT);
                3: queue_unit(dtt_pkg::LF_UNIT);
                4: queue_unit(plain_unit());
                default: queue_unit(16'($urandom));
            endcase
        end
        if ($urandom_range(0, 1) == 1)
            finish_text();
    endtask

    // one text request through the valid/ready handshake
    task automatic send_item(dtt_pkg::item_t it);
        int gap;
        gap = sender_eager ? 0 : int'($urandom_range(0, MAX_GAP));
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid       <= 1'b1;
        text_ch.code_unit   <= it.code_unit;
        text_ch.no_unit     <= it.no_unit;
        text_ch.end_of_text <= it.end_of_text;
        do @(posedge clk); while (!text_ch.ready);
        items_sent++;
    endtask

    // drain the queued text, with stray empty requests mixed in
    task automatic send_text();
        dtt_pkg::item_t it;
        if ($urandom_range(0, 2) == 0)
            sender_eager = !sender_eager;
        while (text_items.size() > 0)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                it.code_unit   = 16'($urandom);
                it.no_unit     = 1'b1;
                it.end_of_text = 1'b0;
            end
            else
                it = text_items.pop_front();
            send_item(it);
        end
    endtask

    // hold the text side until every predicted event is out, then let the
    // pipeline empty of requests that make no event
    task automatic settle();
        text_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_one(logic [1:0] idx, logic [31:0] data);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.reg_index  <= idx;
        cfg_ch.write_data <= data;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic write_regs(bit wd, bit wr, bit wc, logic [dtt_pkg::UNIT_W-1:0] delim,
                              logic [dtt_pkg::ROW_W-1:0] rows,
                              logic [dtt_pkg::COL_W-1:0] cols);
        if (wd)
        begin
            write_one(dtt_pkg::REG_DELIMITER, 32'(delim));
            cur_delim = delim;
        end
        if (wr)
            write_one(dtt_pkg::REG_ROW_LIMIT, 32'(rows));
        if (wc)
            write_one(dtt_pkg::REG_COL_LIMIT, 32'(cols));
        if (wd || wr || wc)
            cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [dtt_pkg::UNIT_W-1:0] d;
        logic [dtt_pkg::ROW_W-1:0]  rl;
        logic [dtt_pkg::COL_W-1:0]  cl;
        bit                         wd;
        bit                         wr;
        bit                         wc;
        int                         phase_start;

        rst_n               <= 1'b0;
        text_ch.valid       <= 1'b0;
        text_ch.code_unit   <= '0;
        text_ch.no_unit     <= 1'b0;
        text_ch.end_of_text <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.reg_index    <= dtt_pkg::REG_DELIMITER;
        cfg_ch.write_data   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass under reset register values
        // doubled quote inside quotes, then the closing quote resolved by a delimiter
        queue_unit(dtt_pkg::QUOTE_UNIT);
        queue_unit(16'd97);
        queue_unit(dtt_pkg::QUOTE_UNIT);
        queue_unit(dtt_pkg::QUOTE_UNIT);
        queue_unit(16'd98);
        queue_unit(dtt_pkg::QUOTE_UNIT);
        queue_unit(dtt_pkg::DELIMITER_RESET);
        // quote inside a non-empty unquoted field is a plain character
        queue_unit(16'd120);
        queue_unit(dtt_pkg::QUOTE_UNIT);
        queue_unit(16'd121);
        // crlf, then a blank line
        queue_unit(dtt_pkg::CR_UNIT);
        queue_unit(dtt_pkg::LF_UNIT);
        queue_unit(dtt_pkg::LF_UNIT);
        // code unit extremes
        queue_unit(16'h0000);
        queue_unit(16'hFFFF);
        queue_unit(dtt_pkg::DELIMITER_RESET);
        // empty request with no text end
        queue_item(16'h5A5A, 1'b1, 1'b0);
        queue_unit(dtt_pkg::CR_UNIT);
        // quote left open when the text ends
        queue_unit(dtt_pkg::QUOTE_UNIT);
        queue_unit(16'd113);
        queue_item(16'd122, 1'b0, 1'b1);
        // empty text, then a text of one blank line
        queue_item(16'hA5A5, 1'b1, 1'b1);
        queue_item(dtt_pkg::LF_UNIT, 1'b0, 1'b1);
        send_text();
        settle();

        // random phases, first ones pinned to fixed settings: register extremes, special delimiters, small limits
        while (items_sent < TARGET_ITEMS)
        begin
            wd = 1'b1;
            wr = 1'b1;
            wc = 1'b1;
            case (phase_count)
                0:
                begin
                    d  = 16'd0;
                    rl = dtt_pkg::ROW_MAX;
                    cl = dtt_pkg::COLUMN_MAX;
                end
                1:
                begin
                    d  = 16'hFFFF;
                    rl = '0;
                    cl = '0;
                end
                2:
                begin
                    d  = dtt_pkg::QUOTE_UNIT;
                    rl = 21'd2;
                    cl = 9'd1;
                end
                3:
                begin
                    d  = dtt_pkg::LF_UNIT;
                    rl = dtt_pkg::ROW_MAX;
                    cl = 9'd2;
                end
                4:
                begin
                    d  = dtt_pkg::CR_UNIT;
                    rl = 21'd3;
                    cl = dtt_pkg::COLUMN_MAX;
                end
                5:
                begin
                    d  = 16'd59;
                    rl = 21'd1;
                    cl = 9'd3;
                end
                default:
                begin
                    wd = 1'($urandom_range(0, 1));
                    wr = 1'($urandom_range(0, 1));
                    wc = 1'($urandom_range(0, 1));
                    case ($urandom_range(0, 7))
                        0: d = 16'd9;
                        1: d = 16'd59;
                        2: d = 16'd124;
                        3: d = dtt_pkg::QUOTE_UNIT;
                        4: d = dtt_pkg::LF_UNIT;
                        5: d = dtt_pkg::CR_UNIT;
                        6: d = 16'($urandom);
                        default: d = dtt_pkg::DELIMITER_RESET;
                    endcase
                    // small row limits stop parsing early, so keep them rare
                    case ($urandom_range(0, 7))
                        0: rl = '0;
                        1: rl = 21'($urandom_range(1, 4));
                        2, 3: rl = 21'($urandom_range(5, 1048576));
                        default: rl = dtt_pkg::ROW_MAX;
                    endcase
                    case ($urandom_range(0, 5))
                        0: cl = '0;
                        1: cl = 9'($urandom_range(1, 4));
                        2: cl = 9'($urandom_range(5, 256));
                        default: cl = dtt_pkg::COLUMN_MAX;
                    endcase
                end
            endcase
            write_regs(wd, wr, wc, d, rl, cl);
            phase_count++;

            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 3) == 0)
                    build_noise();
                else
                    build_table();
                send_text();
            end
            settle();
        end

        $display("covered %0d text requests over %0d register settings after the directed pass",
                 items_sent, phase_count);
        $display("checked %0d token events with random gaps and stalls on both channels",
                 events_checked);
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
